@@ sv/status_led_pattern_sequencer_assert.svh @@
// assertion helpers for the status led pattern sequencer
`ifndef STATUS_LED_PATTERN_SEQUENCER_ASSERT_SVH
`define STATUS_LED_PATTERN_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SLPS_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SLPS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/slps_pkg.sv @@
package slps_pkg;

  // list depth default and field widths
  localparam int LIST_DEPTH_DEF = 6;
  localparam int TIME_W         = 16;
  localparam int THR_W          = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int UPC_W          = 5;

  typedef logic [2:0]        code_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [UPC_W-1:0]  upc_t;

  // status codes
  localparam code_t CODE_INIT    = 3'd0;
  localparam code_t CODE_READY   = 3'd1;
  localparam code_t CODE_NOCARD  = 3'd2;
  localparam code_t CODE_NOHTML  = 3'd3;
  localparam code_t CODE_NOLOGS  = 3'd4;
  localparam code_t CODE_NOWIFI  = 3'd5;
  localparam code_t CODE_NODEV   = 3'd6;
  localparam code_t CODE_UNKNOWN = 3'd7;

  // configuration register reset values
  localparam time_t            BLINK_RST   = 16'd500;
  localparam time_t            PAUSE_RST   = 16'd1500;
  localparam time_t            IDLE_RST    = 16'd2000;
  localparam time_t            UNKNOWN_RST = 16'd2000;
  localparam time_t            READY_RST   = 16'd100;
  localparam logic [THR_W-1:0] THR_RST     = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLINK     = 3'd0,
    CFG_PAUSE     = 3'd1,
    CFG_IDLE      = 3'd2,
    CFG_UNKNOWN   = 3'd3,
    CFG_READY     = 3'd4,
    CFG_THRESHOLD = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_ADD      = 2'd1,
    REQ_REMOVE   = 2'd2,
    REQ_PRESENCE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_PENDING = 2'd0,
    MODE_PATTERN = 2'd1,
    MODE_IDLE    = 2'd2
  } play_mode_e;

  typedef struct packed {
    logic yellow;
    logic green;
    logic red;
  } leds_t;

  localparam leds_t LEDS_OFF    = 3'b000;
  localparam leds_t LEDS_RED    = 3'b001;
  localparam leds_t LEDS_GREEN  = 3'b010;
  localparam leds_t LEDS_YELLOW = 3'b100;

  // which time register sets a phase length
  typedef enum logic [1:0] {
    LEN_BLINK   = 2'd0,
    LEN_PAUSE   = 2'd1,
    LEN_READY   = 2'd2,
    LEN_UNKNOWN = 2'd3
  } len_e;

  typedef struct packed {
    logic  ok;
    leds_t leds;
    len_e  len_sel;
  } phase_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_ACCEPT   = 4'd1,
    OP_RM_GUARD = 4'd2,
    OP_REMOVE   = 4'd3,
    OP_ADD      = 4'd4,
    OP_PRESENCE = 4'd5,
    OP_DEC      = 4'd6,
    OP_STEP_INC = 4'd7,
    OP_POS_INC  = 4'd8,
    OP_START    = 4'd9,
    OP_LOAD     = 4'd10,
    OP_OUTPUT   = 4'd11
  } op_e;

  // operand of the list search
  typedef enum logic [1:0] {
    SEL_ITEM  = 2'd0,
    SEL_READY = 2'd1,
    SEL_NODEV = 2'd2
  } sel_e;

  // branch conditions
  typedef enum logic [3:0] {
    C_NEXT       = 4'd0,
    C_GOTO       = 4'd1,
    C_DISPATCH   = 4'd2,
    C_OUT_FREE   = 4'd3,
    C_PENDING    = 4'd4,
    C_TIMER_NZ   = 4'd5,
    C_MODE_IDLE  = 4'd6,
    C_PHASE_OK   = 4'd7,
    C_POS_IN     = 4'd8,
    C_LIST_EMPTY = 4'd9,
    C_NO_ACT     = 4'd10,
    C_PRESENT    = 4'd11
  } cond_e;

  typedef struct packed {
    op_e   op;
    sel_e  sel;
    cond_e cond;
    upc_t  target;
  } ctrl_t;

  typedef struct packed {
    logic fire;
    req_e req;
    logic pending;
    logic timer_nz;
    logic mode_idle;
    logic phase_ok;
    logic pos_in;
    logic list_empty;
    logic no_act;
    logic present;
    logic out_free;
  } status_t;

  // microcode addresses
  localparam upc_t UA_IDLE     = 5'd0;
  localparam upc_t UA_ADD_RM   = 5'd1;
  localparam upc_t UA_ADD      = 5'd2;
  localparam upc_t UA_REM      = 5'd3;
  localparam upc_t UA_PRES     = 5'd4;
  localparam upc_t UA_PRES_CHK = 5'd5;
  localparam upc_t UA_PRES_DIR = 5'd6;
  localparam upc_t UA_ND_RM    = 5'd7;
  localparam upc_t UA_ND_ADD   = 5'd8;
  localparam upc_t UA_ND_DEL   = 5'd9;
  localparam upc_t UA_T_DEC    = 5'd10;
  localparam upc_t UA_T_CHK    = 5'd11;
  localparam upc_t UA_T_MODE   = 5'd12;
  localparam upc_t UA_T_STEP   = 5'd13;
  localparam upc_t UA_T_PHASE  = 5'd14;
  localparam upc_t UA_T_POS    = 5'd15;
  localparam upc_t UA_T_POSCHK = 5'd16;
  localparam upc_t UA_T_START  = 5'd17;
  localparam upc_t UA_T_LOAD   = 5'd18;
  localparam upc_t UA_DONE     = 5'd19;

  // led pattern table: levels and length source of one phase
  function automatic phase_t pattern_phase(input code_t code, input logic [2:0] step);
    phase_t     ph;
    logic [2:0] pairs;
    leds_t      color;
    logic       blinky;
    ph     = '{ok: 1'b0, leds: LEDS_OFF, len_sel: LEN_PAUSE};
    pairs  = 3'd0;
    color  = LEDS_RED;
    blinky = 1'b0;
    unique case (code)
      CODE_INIT: begin
        pairs  = 3'd1;
        color  = LEDS_GREEN;
        blinky = 1'b1;
      end
      CODE_NOHTML: begin
        pairs  = 3'd3;
        blinky = 1'b1;
      end
      CODE_NOLOGS: begin
        pairs  = 3'd2;
        blinky = 1'b1;
      end
      CODE_READY: begin
        if (step == 3'd0) begin
          ph = '{ok: 1'b1, leds: LEDS_GREEN, len_sel: LEN_READY};
        end else if (step == 3'd1) begin
          ph = '{ok: 1'b1, leds: LEDS_GREEN, len_sel: LEN_PAUSE};
        end
      end
      CODE_NOCARD: begin
        if (step == 3'd0) begin
          ph = '{ok: 1'b1, leds: LEDS_RED, len_sel: LEN_PAUSE};
        end
      end
      CODE_NODEV: begin
        if (step == 3'd0) begin
          ph = '{ok: 1'b1, leds: LEDS_YELLOW, len_sel: LEN_PAUSE};
        end
      end
      CODE_NOWIFI: begin
        if (step == 3'd0) begin
          ph = '{ok: 1'b1, leds: LEDS_RED, len_sel: LEN_BLINK};
        end else if (step == 3'd1) begin
          ph = '{ok: 1'b1, leds: LEDS_OFF, len_sel: LEN_PAUSE};
        end
      end
      default: begin
        if (step == 3'd0) begin
          ph = '{ok: 1'b1, leds: LEDS_OFF, len_sel: LEN_UNKNOWN};
        end else if (step == 3'd1) begin
          ph = '{ok: 1'b1, leds: LEDS_OFF, len_sel: LEN_PAUSE};
        end
      end
    endcase
    // blink pairs followed by a pause
    if (blinky) begin
      if ({1'b0, step} < {pairs, 1'b0}) begin
        ph = '{ok: 1'b1, leds: (step[0] ? LEDS_OFF : color), len_sel: LEN_BLINK};
      end else if ({1'b0, step} == {pairs, 1'b0}) begin
        ph = '{ok: 1'b1, leds: LEDS_OFF, len_sel: LEN_PAUSE};
      end
    end
    return ph;
  endfunction

endpackage

@@ sv/slps_if.sv @@
// request channel
interface slps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [2:0] status_code;
  logic       device_present;

  modport source (output valid, req_type, status_code, device_present, input ready);
  modport sink (input valid, req_type, status_code, device_present, output ready);
endinterface

// result channel
interface slps_out_if;
  logic       valid;
  logic       ready;
  logic       red_on;
  logic       green_on;
  logic       yellow_on;
  logic       code_active;
  logic [2:0] active_count;
  logic       add_dropped;

  modport source (output valid, red_on, green_on, yellow_on, code_active, active_count,
                  add_dropped, input ready);
  modport sink (input valid, red_on, green_on, yellow_on, code_active, active_count,
                add_dropped, output ready);
endinterface

// configuration write channel
interface slps_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [slps_pkg::CFG_IDX_W-1:0]  index;
  logic [slps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/slps_ucode_rom.sv @@
module slps_ucode_rom (
  input  slps_pkg::upc_t  addr_i,
  output slps_pkg::ctrl_t ctrl_o
);

  function automatic slps_pkg::ctrl_t cw(input slps_pkg::op_e op, input slps_pkg::sel_e sel,
                                         input slps_pkg::cond_e cond,
                                         input slps_pkg::upc_t target);
    slps_pkg::ctrl_t w;
    w = '{op: op, sel: sel, cond: cond, target: target};
    return w;
  endfunction

  // control program
  always_comb begin
    unique case (addr_i)
      slps_pkg::UA_IDLE:     ctrl_o = cw(slps_pkg::OP_ACCEPT, slps_pkg::SEL_ITEM,
                                         slps_pkg::C_DISPATCH, slps_pkg::UA_IDLE);
      // add: drop ready unless ready is added, then append
      slps_pkg::UA_ADD_RM:   ctrl_o = cw(slps_pkg::OP_RM_GUARD, slps_pkg::SEL_READY,
                                         slps_pkg::C_NEXT, slps_pkg::UA_IDLE);
      slps_pkg::UA_ADD:      ctrl_o = cw(slps_pkg::OP_ADD, slps_pkg::SEL_ITEM,
                                         slps_pkg::C_GOTO, slps_pkg::UA_DONE);
      slps_pkg::UA_REM:      ctrl_o = cw(slps_pkg::OP_REMOVE, slps_pkg::SEL_ITEM,
                                         slps_pkg::C_GOTO, slps_pkg::UA_DONE);
      // presence debounce
      slps_pkg::UA_PRES:     ctrl_o = cw(slps_pkg::OP_PRESENCE, slps_pkg::SEL_ITEM,
                                         slps_pkg::C_NEXT, slps_pkg::UA_IDLE);
      slps_pkg::UA_PRES_CHK: ctrl_o = cw(slps_pkg::OP_NOP, slps_pkg::SEL_ITEM,
                                         slps_pkg::C_NO_ACT, slps_pkg::UA_DONE);
      slps_pkg::UA_PRES_DIR: ctrl_o = cw(slps_pkg::OP_NOP, slps_pkg::SEL_ITEM,
                                         slps_pkg::C_PRESENT, slps_pkg::UA_ND_DEL);
      slps_pkg::UA_ND_RM:    ctrl_o = cw(slps_pkg::OP_REMOVE, slps_pkg::SEL_READY,
                                         slps_pkg::C_NEXT, slps_pkg::UA_IDLE);
      slps_pkg::UA_ND_ADD:   ctrl_o = cw(slps_pkg::OP_ADD, slps_pkg::SEL_NODEV,
                                         slps_pkg::C_GOTO, slps_pkg::UA_DONE);
      slps_pkg::UA_ND_DEL:   ctrl_o = cw(slps_pkg::OP_REMOVE, slps_pkg::SEL_NODEV,
                                         slps_pkg::C_GOTO, slps_pkg::UA_DONE);
      // tick: count down, advance phase, position or round
      slps_pkg::UA_T_DEC:    ctrl_o = cw(slps_pkg::OP_DEC, slps_pkg::SEL_ITEM,
                                         slps_pkg::C_PENDING, slps_pkg::UA_T_START);
      slps_pkg::UA_T_CHK:    ctrl_o = cw(slps_pkg::OP_NOP, slps_pkg::SEL_ITEM,
                                         slps_pkg::C_TIMER_NZ, slps_pkg::UA_DONE);
      slps_pkg::UA_T_MODE:   ctrl_o = cw(slps_pkg::OP_NOP, slps_pkg::SEL_ITEM,
                                         slps_pkg::C_MODE_IDLE, slps_pkg::UA_T_START);
      slps_pkg::UA_T_STEP:   ctrl_o = cw(slps_pkg::OP_STEP_INC, slps_pkg::SEL_ITEM,
                                         slps_pkg::C_NEXT, slps_pkg::UA_IDLE);
      slps_pkg::UA_T_PHASE:  ctrl_o = cw(slps_pkg::OP_NOP, slps_pkg::SEL_ITEM,
                                         slps_pkg::C_PHASE_OK, slps_pkg::UA_T_LOAD);
      slps_pkg::UA_T_POS:    ctrl_o = cw(slps_pkg::OP_POS_INC, slps_pkg::SEL_ITEM,
                                         slps_pkg::C_NEXT, slps_pkg::UA_IDLE);
      slps_pkg::UA_T_POSCHK: ctrl_o = cw(slps_pkg::OP_NOP, slps_pkg::SEL_ITEM,
                                         slps_pkg::C_POS_IN, slps_pkg::UA_T_LOAD);
      slps_pkg::UA_T_START:  ctrl_o = cw(slps_pkg::OP_START, slps_pkg::SEL_NODEV,
                                         slps_pkg::C_LIST_EMPTY, slps_pkg::UA_DONE);
      slps_pkg::UA_T_LOAD:   ctrl_o = cw(slps_pkg::OP_LOAD, slps_pkg::SEL_ITEM,
                                         slps_pkg::C_GOTO, slps_pkg::UA_DONE);
      // result register write
      slps_pkg::UA_DONE:     ctrl_o = cw(slps_pkg::OP_OUTPUT, slps_pkg::SEL_ITEM,
                                         slps_pkg::C_OUT_FREE, slps_pkg::UA_IDLE);
      default:               ctrl_o = cw(slps_pkg::OP_NOP, slps_pkg::SEL_ITEM,
                                         slps_pkg::C_GOTO, slps_pkg::UA_IDLE);
    endcase
  end

endmodule

@@ sv/slps_sequencer.sv @@
module slps_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slps_pkg::status_t status_i,
  output slps_pkg::ctrl_t   ctrl_o
);

  slps_pkg::upc_t upc_q, upc_d;
  slps_pkg::upc_t dispatch;
  logic           take;

  slps_ucode_rom u_rom (
    .addr_i (upc_q),
    .ctrl_o (ctrl_o)
  );

  // entry point of each request kind
  always_comb begin
    unique case (status_i.req)
      slps_pkg::REQ_TICK:     dispatch = slps_pkg::UA_T_DEC;
      slps_pkg::REQ_ADD:      dispatch = slps_pkg::UA_ADD_RM;
      slps_pkg::REQ_REMOVE:   dispatch = slps_pkg::UA_REM;
      slps_pkg::REQ_PRESENCE: dispatch = slps_pkg::UA_PRES;
    endcase
  end

  // branch condition select
  always_comb begin
    unique case (ctrl_o.cond)
      slps_pkg::C_PENDING:    take = status_i.pending;
      slps_pkg::C_TIMER_NZ:   take = status_i.timer_nz;
      slps_pkg::C_MODE_IDLE:  take = status_i.mode_idle;
      slps_pkg::C_PHASE_OK:   take = status_i.phase_ok;
      slps_pkg::C_POS_IN:     take = status_i.pos_in;
      slps_pkg::C_LIST_EMPTY: take = status_i.list_empty;
      slps_pkg::C_NO_ACT:     take = status_i.no_act;
      slps_pkg::C_PRESENT:    take = status_i.present;
      default:                take = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    unique case (ctrl_o.cond)
      slps_pkg::C_NEXT:     upc_d = upc_q + 5'd1;
      slps_pkg::C_GOTO:     upc_d = ctrl_o.target;
      slps_pkg::C_DISPATCH: upc_d = status_i.fire ? dispatch : upc_q;
      slps_pkg::C_OUT_FREE: upc_d = status_i.out_free ? ctrl_o.target : upc_q;
      default:              upc_d = take ? ctrl_o.target : upc_q + 5'd1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= slps_pkg::UA_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

@@ sv/slps_datapath.sv @@
module slps_datapath #(
  parameter int LIST_DEPTH = slps_pkg::LIST_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slps_pkg::ctrl_t   ctrl_i,
  output slps_pkg::status_t status_o,
  slps_in_if.sink           req_i,
  slps_out_if.source        res_o,
  slps_cfg_if.sink          cfg_i
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

  // configuration registers
  slps_pkg::time_t                blink_q, pause_q, idle_q, unknown_q, ready_q;
  logic [slps_pkg::THR_W-1:0]     thr_q;

  // latched request
  slps_pkg::code_t  code_q;
  logic             present_q;
  logic             dropped_q, dropped_d;

  // code list and round snapshot
  slps_pkg::code_t  list_q [LIST_DEPTH];
  slps_pkg::code_t  list_d [LIST_DEPTH];
  slps_pkg::code_t  round_q [LIST_DEPTH];
  slps_pkg::code_t  round_d [LIST_DEPTH];
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rcount_q, rcount_d;

  // playback state
  logic [CNT_W-1:0]        pos_q, pos_d;
  logic [2:0]              step_q, step_d;
  slps_pkg::play_mode_e    mode_q, mode_d;
  slps_pkg::time_t         timer_q, timer_d;
  slps_pkg::leds_t         leds_q, leds_d;
  logic [slps_pkg::THR_W-1:0] absent_q, absent_d, prun_q, prun_d;

  // result register
  logic             out_valid_q;
  slps_pkg::leds_t  res_leds_q;
  logic             res_active_q;
  logic [2:0]       res_count_q;
  logic             res_drop_q;

  slps_pkg::code_t  operand;
  logic [LIST_DEPTH-1:0] hit, after;
  logic             found;
  slps_pkg::phase_t ph;
  slps_pkg::time_t  len;
  logic [slps_pkg::THR_W-1:0] thr;
  logic             act;
  logic             fire;
  logic             out_free;
  logic [CNT_W+2:0] cnt_ext;

  assign fire     = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || res_o.ready;
  assign cnt_ext  = {3'b000, count_q};
  assign req_i.ready = (ctrl_i.op == slps_pkg::OP_ACCEPT);
  assign cfg_i.ready = 1'b1;

  // search operand
  always_comb begin
    unique case (ctrl_i.sel)
      slps_pkg::SEL_ITEM:  operand = code_q;
      slps_pkg::SEL_READY: operand = slps_pkg::CODE_READY;
      slps_pkg::SEL_NODEV: operand = slps_pkg::CODE_NODEV;
      default:             operand = code_q;
    endcase
  end

  // parallel list search and shift mask
  always_comb begin
    for (int j = 0; j < LIST_DEPTH; j++) begin
      hit[j] = (CNT_W'(j) < count_q) && (list_q[j] == operand);
    end
    after[0] = hit[0];
    for (int j = 1; j < LIST_DEPTH; j++) begin
      after[j] = after[j-1] | hit[j];
    end
  end
  assign found = |hit;

  // phase table lookup on current position
  assign ph = slps_pkg::pattern_phase(round_q[pos_q[IDX_W-1:0]], step_q);

  always_comb begin
    unique case (ph.len_sel)
      slps_pkg::LEN_BLINK:   len = blink_q;
      slps_pkg::LEN_PAUSE:   len = pause_q;
      slps_pkg::LEN_READY:   len = ready_q;
      slps_pkg::LEN_UNKNOWN: len = unknown_q;
    endcase
  end

  // debounce threshold
  assign thr = (thr_q == '0) ? 8'd1 : thr_q;
  assign act = present_q ? (prun_q >= thr) : (absent_q >= thr);

  // status for the sequencer
  always_comb begin
    status_o.fire       = fire;
    status_o.req        = slps_pkg::req_e'(req_i.req_type);
    status_o.pending    = (mode_q == slps_pkg::MODE_PENDING);
    status_o.timer_nz   = (timer_q != '0);
    status_o.mode_idle  = (mode_q == slps_pkg::MODE_IDLE);
    status_o.phase_ok   = ph.ok;
    status_o.pos_in     = (pos_q < rcount_q);
    status_o.list_empty = (count_q == '0);
    status_o.no_act     = !act;
    status_o.present    = present_q;
    status_o.out_free   = out_free;
  end

  // micro-operation execution
  always_comb begin
    list_d    = list_q;
    round_d   = round_q;
    count_d   = count_q;
    rcount_d  = rcount_q;
    pos_d     = pos_q;
    step_d    = step_q;
    mode_d    = mode_q;
    timer_d   = timer_q;
    leds_d    = leds_q;
    absent_d  = absent_q;
    prun_d    = prun_q;
    dropped_d = dropped_q;
    unique case (ctrl_i.op)
      slps_pkg::OP_ACCEPT: begin
        if (fire) begin
          dropped_d = 1'b0;
        end
      end
      slps_pkg::OP_RM_GUARD, slps_pkg::OP_REMOVE: begin
        if (found && (ctrl_i.op == slps_pkg::OP_REMOVE || code_q != slps_pkg::CODE_READY)) begin
          for (int j = 0; j < LIST_DEPTH - 1; j++) begin
            if (after[j]) begin
              list_d[j] = list_q[j+1];
            end
          end
          count_d = count_q - CNT_W'(1);
        end
      end
      slps_pkg::OP_ADD: begin
        if (!found) begin
          if (count_q >= DEPTH_C) begin
            dropped_d = 1'b1;
          end else begin
            list_d[count_q[IDX_W-1:0]] = operand;
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      slps_pkg::OP_PRESENCE: begin
        if (present_q) begin
          if (prun_q != 8'hFF) begin
            prun_d = prun_q + 8'd1;
          end
          absent_d = '0;
        end else begin
          if (absent_q != 8'hFF) begin
            absent_d = absent_q + 8'd1;
          end
          prun_d = '0;
        end
      end
      slps_pkg::OP_DEC: begin
        if (mode_q != slps_pkg::MODE_PENDING && timer_q != '0) begin
          timer_d = timer_q - 16'd1;
        end
      end
      slps_pkg::OP_STEP_INC: begin
        step_d = step_q + 3'd1;
      end
      slps_pkg::OP_POS_INC: begin
        pos_d  = pos_q + CNT_W'(1);
        step_d = 3'd0;
      end
      slps_pkg::OP_START: begin
        if (found) begin
          // no-device code plays alone
          round_d[0] = slps_pkg::CODE_NODEV;
          rcount_d   = CNT_W'(1);
          mode_d     = slps_pkg::MODE_PATTERN;
          pos_d      = '0;
          step_d     = 3'd0;
        end else if (count_q == '0) begin
          mode_d  = slps_pkg::MODE_IDLE;
          leds_d  = slps_pkg::LEDS_GREEN;
          timer_d = (idle_q == '0) ? 16'd1 : idle_q;
        end else begin
          round_d  = list_q;
          rcount_d = count_q;
          mode_d   = slps_pkg::MODE_PATTERN;
          pos_d    = '0;
          step_d   = 3'd0;
        end
      end
      slps_pkg::OP_LOAD: begin
        leds_d  = ph.leds;
        timer_d = (len == '0) ? 16'd1 : len;
      end
      default: begin
      end
    endcase
  end

  // control and list registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < LIST_DEPTH; j++) begin
        list_q[j] <= slps_pkg::CODE_INIT;
      end
      count_q   <= CNT_W'(1);
      rcount_q  <= '0;
      pos_q     <= '0;
      step_q    <= 3'd0;
      mode_q    <= slps_pkg::MODE_PENDING;
      timer_q   <= '0;
      leds_q    <= slps_pkg::LEDS_OFF;
      absent_q  <= '0;
      prun_q    <= '0;
      dropped_q <= 1'b0;
    end else begin
      list_q    <= list_d;
      count_q   <= count_d;
      rcount_q  <= rcount_d;
      pos_q     <= pos_d;
      step_q    <= step_d;
      mode_q    <= mode_d;
      timer_q   <= timer_d;
      leds_q    <= leds_d;
      absent_q  <= absent_d;
      prun_q    <= prun_d;
      dropped_q <= dropped_d;
    end
  end

  // round snapshot, written before it is read
  always_ff @(posedge clk_i) begin
    round_q <= round_d;
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (fire) begin
      code_q    <= req_i.status_code;
      present_q <= req_i.device_present;
    end
  end

  // configuration writes, unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_q   <= slps_pkg::BLINK_RST;
      pause_q   <= slps_pkg::PAUSE_RST;
      idle_q    <= slps_pkg::IDLE_RST;
      unknown_q <= slps_pkg::UNKNOWN_RST;
      ready_q   <= slps_pkg::READY_RST;
      thr_q     <= slps_pkg::THR_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        slps_pkg::CFG_BLINK:     blink_q   <= cfg_i.data;
        slps_pkg::CFG_PAUSE:     pause_q   <= cfg_i.data;
        slps_pkg::CFG_IDLE:      idle_q    <= cfg_i.data;
        slps_pkg::CFG_UNKNOWN:   unknown_q <= cfg_i.data;
        slps_pkg::CFG_READY:     ready_q   <= cfg_i.data;
        slps_pkg::CFG_THRESHOLD: thr_q     <= cfg_i.data[slps_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.op == slps_pkg::OP_OUTPUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == slps_pkg::OP_OUTPUT && out_free) begin
      res_leds_q   <= leds_q;
      res_active_q <= found;
      res_count_q  <= cnt_ext[2:0];
      res_drop_q   <= dropped_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.red_on       = res_leds_q.red;
  assign res_o.green_on     = res_leds_q.green;
  assign res_o.yellow_on    = res_leds_q.yellow;
  assign res_o.code_active  = res_active_q;
  assign res_o.active_count = res_count_q;
  assign res_o.add_dropped  = res_drop_q;

endmodule

@@ sv/status_led_pattern_sequencer.sv @@
// Results: a result is registered at the end of the microcode path of each request,
// and the length of that path is set by the request kind and the playback state.
// Flow: requests are handled one at a time; the next request is taken once the
// microcode sequencer returns to its idle step and the result register is free.
// Reset: the code list holds the init code, playback waits for the first tick to
// start a round, configuration takes its default values; the round list is not cleared.
`include "status_led_pattern_sequencer_assert.svh"

module status_led_pattern_sequencer #(
  parameter int LIST_DEPTH = slps_pkg::LIST_DEPTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  slps_in_if.sink    req_i,
  slps_out_if.source res_o,
  slps_cfg_if.sink   cfg_i
);

  slps_pkg::ctrl_t   ctrl;
  slps_pkg::status_t status;

  // microcode sequencer
  slps_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // list, playback and result datapath
  slps_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .status_o (status),
    .req_i    (req_i),
    .res_o    (res_o),
    .cfg_i    (cfg_i)
  );

  // a taken request leaves the idle step
  `SLPS_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready, "request taken while previous one still in work")

  // a new result only comes from the output step
  `SLPS_ASSERT_IMPL(a_result_from_done, clk_i, rst_ni, $rose(res_o.valid), $past(ctrl.op == slps_pkg::OP_OUTPUT), "result valid raised outside the output step")

endmodule
